// File: rtl/tswp_pkg.sv
// Shared types, widths and constants for the three-step wrapped phase unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package tswp_pkg;

	localparam int SAMPLE_W = 8;
	localparam int NUM_W = 10;
	localparam int DEN_W = 11;
	localparam int XY_W = 38;
	localparam int ANG_W = 32;
	localparam int PHASE_W = 16;
	localparam int CODE_W = 8;
	localparam int PROD_W = ANG_W + CODE_W;
	localparam int CORDIC_STEPS = 24;
	localparam int DEN_SHIFT = 24;
	localparam int ANG_FRAC = 30;
	localparam int PHASE_FRAC_BITS_DEF = 14;

	localparam int CODE_EST_W = 16;
	localparam int CODE_RCP_W = 17;
	localparam int EST_W = CODE_EST_W + CODE_RCP_W;
	localparam int CODE_RCP_SHIFT = 24;

	localparam logic FORMULA_DIFF = 1'b0;
	localparam logic FORMULA_SUM = 1'b1;

	localparam logic [25:0] SQRT3_Q24 = 26'd29058991;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 32'sd1686629713;
	localparam logic [ANG_W-1:0] PI_Q30 = 32'd3373259426;
	localparam logic [PHASE_W-1:0] PHASE_POS_MAX = 16'h7FFF;
	localparam logic [PHASE_W-1:0] PHASE_NEG_MAX = 16'h8000;

	// 255 * 2^40 / PI_Q30, truncated; the code estimate is low by at most one
	localparam logic [CODE_RCP_W-1:0] CODE_RCP = 17'd83117;

	localparam logic signed [ANG_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
		32'sd67021686, 32'sd33543515, 32'sd16775850, 32'sd8388437,
		32'sd4194282, 32'sd2097149, 32'sd1048575, 32'sd524287,
		32'sd262143, 32'sd131071, 32'sd65535, 32'sd32767,
		32'sd16383, 32'sd8191, 32'sd4095, 32'sd2047,
		32'sd1023, 32'sd511, 32'sd255, 32'sd127
	};

	typedef struct packed {
		logic special;
		logic neg;
		logic undef;
	} side_t;

	// arithmetic shift right, rounded toward zero
	function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
			input int s);
		logic signed [XY_W-1:0] asr;
		logic fnz;
		asr = v >>> s;
		fnz = (v << (XY_W - s)) != '0;
		return asr + {{(XY_W-1){1'b0}}, (v[XY_W-1] & fnz)};
	endfunction

endpackage

`default_nettype wire

// File: rtl/tswp_front.sv
// Front end: forms numerator/denominator from the three samples, folds the
// sign into the numerator and scales both into CORDIC start vectors. Uses tswp_pkg.
`default_nettype none

module tswp_front
	import tswp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic mode,
	input wire logic [SAMPLE_W-1:0] sample_a,
	input wire logic [SAMPLE_W-1:0] sample_b,
	input wire logic [SAMPLE_W-1:0] sample_c,
	output logic out_valid,
	output logic signed [XY_W-1:0] x_out,
	output logic signed [XY_W-1:0] y_out,
	output side_t side_out
);

	logic signed [DEN_W-1:0] a_e, b_e, c_e;
	logic signed [DEN_W-1:0] num_c, den_c;
	logic signed [NUM_W-1:0] num_s1;
	logic signed [DEN_W-1:0] den_s1;
	logic v_s1;

	logic signed [NUM_W-1:0] num_n;
	logic signed [DEN_W-1:0] den_n;
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] prod;
	side_t side_c;

	assign a_e = DEN_W'(signed'({1'b0, sample_a}));
	assign b_e = DEN_W'(signed'({1'b0, sample_b}));
	assign c_e = DEN_W'(signed'({1'b0, sample_c}));

	always_comb begin
		if (mode == FORMULA_SUM) begin
			num_c = a_e - b_e;
			den_c = (c_e <<< 1) - a_e - b_e;
		end else begin
			num_c = a_e - c_e;
			den_c = (b_e <<< 1) - a_e - c_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_s1 <= NUM_W'(num_c);
		den_s1 <= den_c;
	end

	always_comb begin
		side_c.special = den_s1 == '0;
		side_c.neg = num_s1 < 0;
		side_c.undef = (den_s1 == '0) && (num_s1 == '0);
		if (den_s1 < 0) begin
			num_n = -num_s1;
			den_n = -den_s1;
		end else begin
			num_n = num_s1;
			den_n = den_s1;
		end
		dx = XY_W'(den_n);
		prod = XY_W'(num_n) * XY_W'(signed'({1'b0, SQRT3_Q24}));
	end

	always_ff @(posedge clk) begin
		x_out <= dx <<< DEN_SHIFT;
		y_out <= prod;
		side_out <= side_c;
	end

endmodule

`default_nettype wire

// File: rtl/tswp_cordic.sv
// Vectoring CORDIC arctangent, one micro-rotation per pipeline stage.
// Uses tswp_pkg for widths, the angle table and the shift helper.
`default_nettype none

module tswp_cordic
	import tswp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic signed [XY_W-1:0] x_in,
	input wire logic signed [XY_W-1:0] y_in,
	input wire side_t side_in,
	output logic out_valid,
	output logic signed [ANG_W-1:0] z_out,
	output side_t side_out
);

	logic signed [XY_W-1:0] x_s [CORDIC_STEPS];
	logic signed [XY_W-1:0] y_s [CORDIC_STEPS];
	logic signed [ANG_W-1:0] z_s [CORDIC_STEPS];
	side_t side_s [CORDIC_STEPS];
	logic [CORDIC_STEPS-1:0] v_s;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XY_W-1:0] xp, yp, xs, ys;
		logic signed [ANG_W-1:0] zp;
		side_t sp;
		logic vp;

		if (i == 0) begin : g_first
			assign xp = x_in;
			assign yp = y_in;
			assign zp = '0;
			assign sp = side_in;
			assign vp = in_valid;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign sp = side_s[i-1];
			assign vp = v_s[i-1];
		end

		assign xs = shr_tz(xp, i);
		assign ys = shr_tz(yp, i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			side_s[i] <= sp;
			if (yp > 0) begin
				x_s[i] <= xp + ys;
				y_s[i] <= yp - xs;
				z_s[i] <= zp + ATAN_Q30[i];
			end else begin
				x_s[i] <= xp - ys;
				y_s[i] <= yp + xs;
				z_s[i] <= zp - ATAN_Q30[i];
			end
		end
	end

	assign out_valid = v_s[CORDIC_STEPS-1];
	assign z_out = z_s[CORDIC_STEPS-1];
	assign side_out = side_s[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// File: rtl/tswp_post.sv
// Back end: special-case select and clamp, rounding/saturation to the output
// Q format, and the byte code from a reciprocal estimate and one correction. Uses tswp_pkg.
`default_nettype none

module tswp_post
	import tswp_pkg::*;
#(
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic signed [ANG_W-1:0] z_in,
	input wire side_t side_in,
	output logic out_valid,
	output logic [PHASE_W-1:0] phase_out,
	output logic [CODE_W-1:0] code_out,
	output logic flag_out
);

	localparam int SH = ANG_FRAC - PHASE_FRAC_BITS;
	localparam int RND_W = ANG_W - SH;

	logic signed [ANG_W-1:0] zsel_c;
	logic signed [ANG_W-1:0] z_s1;
	logic fl_s1, v_s1;

	logic [ANG_W-1:0] t_s2;
	logic [ANG_W-2:0] mag_s2;
	logic neg_s2, fl_s2, v_s2;

	logic [ANG_W-1:0] rsum_c;
	logic [EST_W-1:0] est_c;
	logic [RND_W-1:0] rnd_s3;
	logic [PROD_W-1:0] p_s3;
	logic [CODE_W-1:0] q0_s3;
	logic neg_s3, fl_s3, v_s3;

	logic [PHASE_W-1:0] ph_c;
	logic [PHASE_W-1:0] ph_s4;
	logic [PROD_W-1:0] p_s4, nxt_s4;
	logic [CODE_W-1:0] q0_s4;
	logic fl_s4, v_s4;

	logic [PHASE_W-1:0] ph_s5;
	logic [CODE_W-1:0] code_s5;
	logic fl_s5, v_s5;

	// special cases and clamp to +-pi/2
	always_comb begin
		if (side_in.special) begin
			if (side_in.undef) begin
				zsel_c = '0;
			end else if (side_in.neg) begin
				zsel_c = -HALF_PI_Q30;
			end else begin
				zsel_c = HALF_PI_Q30;
			end
		end else if (z_in > HALF_PI_Q30) begin
			zsel_c = HALF_PI_Q30;
		end else if (z_in < -HALF_PI_Q30) begin
			zsel_c = -HALF_PI_Q30;
		end else begin
			zsel_c = z_in;
		end
	end

	assign rsum_c = {1'b0, mag_s2} + (ANG_W'(1) << (SH - 1));

	// code estimate from the top bits of the offset angle
	assign est_c = EST_W'(t_s2[ANG_W-1 -: CODE_EST_W]) * EST_W'(CODE_RCP);

	always_comb begin
		if (neg_s3) begin
			ph_c = (ANG_W'(rnd_s3) > ANG_W'(PHASE_NEG_MAX)) ? PHASE_NEG_MAX :
				PHASE_W'(0) - PHASE_W'(rnd_s3);
		end else begin
			ph_c = (ANG_W'(rnd_s3) > ANG_W'(PHASE_POS_MAX)) ? PHASE_POS_MAX :
				PHASE_W'(rnd_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		z_s1 <= zsel_c;
		fl_s1 <= side_in.special & side_in.undef;

		t_s2 <= ANG_W'(z_s1 + HALF_PI_Q30);
		mag_s2 <= (z_s1 < 0) ? (ANG_W-1)'(-z_s1) : (ANG_W-1)'(z_s1);
		neg_s2 <= z_s1 < 0;
		fl_s2 <= fl_s1;

		rnd_s3 <= RND_W'(rsum_c >> SH);
		p_s3 <= (PROD_W'(t_s2) << CODE_W) - PROD_W'(t_s2);
		q0_s3 <= est_c[CODE_RCP_SHIFT +: CODE_W];
		neg_s3 <= neg_s2;
		fl_s3 <= fl_s2;

		ph_s4 <= ph_c;
		p_s4 <= p_s3;
		q0_s4 <= q0_s3;
		nxt_s4 <= PROD_W'({1'b0, q0_s3} + (CODE_W+1)'(1)) * PROD_W'(PI_Q30);
		fl_s4 <= fl_s3;

		ph_s5 <= ph_s4;
		code_s5 <= q0_s4 + CODE_W'(p_s4 >= nxt_s4);
		fl_s5 <= fl_s4;
	end

	assign out_valid = v_s5;
	assign phase_out = ph_s5;
	assign code_out = code_s5;
	assign flag_out = fl_s5;

endmodule

`default_nettype wire

// File: rtl/three_step_wrapped_phase_unit.sv
// Top level of the three-step wrapped phase unit: config register and
// pipeline. Depends on tswp_pkg, tswp_front, tswp_cordic and tswp_post.
//
// Usage:
//   Input: drive sample_a/b/c and pulse start; a word is taken at each edge
//   with start high and busy low. busy stays low, so a word can enter on
//   every clock.
//   Output: done is high for one cycle with phase_fixed, phase_code and
//   undefined_flag valid in that cycle. The receiver cannot stall; results
//   leave in input order.
//   Pipeline: an accepted word passes 2 front stages, 24 CORDIC stages and
//   5 back-end stages for rounding and the byte code; the last back-end
//   stage drives done. Throughput: one word per clock.
//   Config: formula_mode is written on cfg_data when cfg_valid is high;
//   cfg_ready is always high. Write it only while the pipeline is empty.
//   Reset: arst_n clears all valid bits and sets formula_mode to 0.
`default_nettype none

module three_step_wrapped_phase_unit
	import tswp_pkg::*;
#(
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [SAMPLE_W-1:0] sample_a,
	input wire logic [SAMPLE_W-1:0] sample_b,
	input wire logic [SAMPLE_W-1:0] sample_c,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_data,
	output logic done,
	output logic signed [PHASE_W-1:0] phase_fixed,
	output logic [CODE_W-1:0] phase_code,
	output logic undefined_flag
);

	logic formula_mode_q;
	logic accept;

	logic f_valid;
	logic signed [XY_W-1:0] f_x, f_y;
	side_t f_side;

	logic c_valid;
	logic signed [ANG_W-1:0] c_z;
	side_t c_side;

	logic [PHASE_W-1:0] p_phase;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			formula_mode_q <= FORMULA_DIFF;
		end else if (cfg_valid && cfg_ready) begin
			formula_mode_q <= cfg_data;
		end
	end

	tswp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.mode(formula_mode_q),
		.sample_a(sample_a),
		.sample_b(sample_b),
		.sample_c(sample_c),
		.out_valid(f_valid),
		.x_out(f_x),
		.y_out(f_y),
		.side_out(f_side)
	);

	tswp_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(f_valid),
		.x_in(f_x),
		.y_in(f_y),
		.side_in(f_side),
		.out_valid(c_valid),
		.z_out(c_z),
		.side_out(c_side)
	);

	tswp_post #(
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(c_valid),
		.z_in(c_z),
		.side_in(c_side),
		.out_valid(done),
		.phase_out(p_phase),
		.code_out(phase_code),
		.flag_out(undefined_flag)
	);

	assign phase_fixed = signed'(p_phase);

endmodule

`default_nettype wire

// File: tb/tb_three_step_wrapped_phase_unit.sv
// Self-checking testbench for three_step_wrapped_phase_unit: directed and random pixels
// in both formula modes, with sender idling, checked against an in-bench CORDIC predictor.
// Depends on tswp_pkg and the unit's RTL.
`default_nettype none

module tb_three_step_wrapped_phase_unit;
	import tswp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 14;
	localparam int ROUND_SHIFT = 30 - FRAC_BITS;
	localparam longint HALF_PI_ANG = 64'sd1686629713;
	localparam longint SQRT3_SCALED = 64'sd29058991;
	localparam int ATAN_STEPS = 24;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} pixel_t;

	typedef struct packed {
		logic signed [15:0] phase;
		logic [7:0] code;
		logic undef;
	} phase_word_t;

	logic clk;
	logic arst_n;
	logic start = 1'b0;
	logic busy;
	logic [7:0] sample_a = '0;
	logic [7:0] sample_b = '0;
	logic [7:0] sample_c = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = FORMULA_DIFF;
	logic done;
	logic signed [15:0] phase_fixed;
	logic [7:0] phase_code;
	logic undefined_flag;

	longint atan_step [ATAN_STEPS] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127
	};

	pixel_t pixel_q [$];
	phase_word_t phase_expect_q [$];
	pixel_t next_pixel;
	logic mode_copy;
	int sender_idle_pct = 0;
	int n_pixels = 0;
	int n_words = 0;
	int n_undefined = 0;
	int n_rail = 0;
	int n_phases = 0;
	int n_errors = 0;

	three_step_wrapped_phase_unit #(
		.PHASE_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample_a(sample_a),
		.sample_b(sample_b),
		.sample_c(sample_c),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.phase_fixed(phase_fixed),
		.phase_code(phase_code),
		.undefined_flag(undefined_flag)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint shift_toward_zero(longint v, int s);
		if (v < 0)
			return -((-v) >>> s);
		return v >>> s;
	endfunction

	function automatic phase_word_t predict_phase(pixel_t p, logic mode);
		longint num, den, x, y, z, xs, ys, code, mag, rounded;
		phase_word_t w;
		w.undef = 1'b0;
		z = 0;
		if (mode == FORMULA_DIFF) begin
			num = longint'(p.a) - longint'(p.c);
			den = 2 * longint'(p.b) - longint'(p.a) - longint'(p.c);
		end else begin
			num = longint'(p.a) - longint'(p.b);
			den = 2 * longint'(p.c) - longint'(p.a) - longint'(p.b);
		end
		if (den == 0) begin
			if (num > 0)
				z = HALF_PI_ANG;
			else if (num < 0)
				z = -HALF_PI_ANG;
			else
				w.undef = 1'b1;
		end else begin
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			x = den * (64'sd1 <<< 24);
			y = num * SQRT3_SCALED;
			for (int i = 0; i < ATAN_STEPS; i++) begin
				xs = shift_toward_zero(x, i);
				ys = shift_toward_zero(y, i);
				if (y > 0) begin
					x = x + ys;
					y = y - xs;
					z = z + atan_step[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - atan_step[i];
				end
			end
			if (z > HALF_PI_ANG)
				z = HALF_PI_ANG;
			if (z < -HALF_PI_ANG)
				z = -HALF_PI_ANG;
		end
		code = ((z + HALF_PI_ANG) * 255) / (2 * HALF_PI_ANG);
		if (code < 0)
			code = 0;
		if (code > 255)
			code = 255;
		mag = (z < 0) ? -z : z;
		mag = (mag + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		rounded = (z < 0) ? -mag : mag;
		if (rounded > 32767)
			rounded = 32767;
		if (rounded < -32768)
			rounded = -32768;
		w.phase = rounded[15:0];
		w.code = code[7:0];
		return w;
	endfunction

	// random pixel: mostly uniform, with flat pixels and zero-denominator pixels mixed in
	function automatic pixel_t make_pixel(logic mode);
		pixel_t p;
		int kind;
		logic [8:0] total;
		kind = $urandom_range(99);
		p.a = $urandom_range(255);
		p.b = $urandom_range(255);
		p.c = $urandom_range(255);
		if (kind < 8) begin
			p.b = p.a;
			p.c = p.a;
		end else if (kind < 22) begin
			if (mode == FORMULA_DIFF) begin
				p.c = {p.c[7:1], p.a[0]};
				total = p.a + p.c;
				p.b = total[8:1];
			end else begin
				p.b = {p.b[7:1], p.a[0]};
				total = p.a + p.b;
				p.c = total[8:1];
			end
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_copy <= FORMULA_DIFF;
		end else if (cfg_valid && cfg_ready) begin
			mode_copy <= cfg_data;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			sample_a <= '0;
			sample_b <= '0;
			sample_c <= '0;
		end else begin
			if (start && !busy) begin
				phase_expect_q.push_back(predict_phase({sample_a, sample_b, sample_c},
						mode_copy));
				n_pixels++;
			end
			if (!start || !busy) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					next_pixel = pixel_q.pop_front();
					start <= 1'b1;
					sample_a <= next_pixel.a;
					sample_b <= next_pixel.b;
					sample_c <= next_pixel.c;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic flag_error(string what);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		phase_word_t want;
		if (arst_n && done) begin
			n_words++;
			if (undefined_flag)
				n_undefined++;
			if (phase_code == 8'd0 || phase_code == 8'd255)
				n_rail++;
			if (phase_expect_q.size() == 0) begin
				flag_error($sformatf("unexpected word phase=%0d code=%0d undef=%0b",
						phase_fixed, phase_code, undefined_flag));
			end else begin
				want = phase_expect_q.pop_front();
				if (phase_fixed !== want.phase)
					flag_error($sformatf("phase_fixed exp %0d got %0d", want.phase,
							phase_fixed));
				if (phase_code !== want.code)
					flag_error($sformatf("phase_code exp %0d got %0d", want.code,
							phase_code));
				if (undefined_flag !== want.undef)
					flag_error($sformatf("undefined_flag exp %0b got %0b", want.undef,
							undefined_flag));
			end
		end
	end

	task automatic write_mode(logic mode);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pixel_q.size() != 0 || start || phase_expect_q.size() != 0);
	endtask

	task automatic push_pixel(int a, int b, int c);
		pixel_q.push_back({a[7:0], b[7:0], c[7:0]});
	endtask

	task automatic run_random(logic mode, int idle_pct, int count);
		write_mode(mode);
		sender_idle_pct = idle_pct;
		n_phases++;
		for (int i = 0; i < count; i++)
			pixel_q.push_back(make_pixel(mode));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// difference form: flat, extremes, zero denominator both signs, negative den
		write_mode(FORMULA_DIFF);
		n_phases++;
		push_pixel(0, 0, 0);
		push_pixel(255, 255, 255);
		push_pixel(255, 0, 0);
		push_pixel(0, 255, 0);
		push_pixel(0, 0, 255);
		push_pixel(255, 0, 255);
		push_pixel(0, 127, 254);
		push_pixel(254, 127, 0);
		push_pixel(200, 0, 100);
		push_pixel(255, 255, 0);
		push_pixel(1, 0, 0);
		push_pixel(0, 1, 0);
		drain();

		write_mode(FORMULA_SUM);
		n_phases++;
		push_pixel(0, 0, 0);
		push_pixel(255, 255, 255);
		push_pixel(255, 0, 0);
		push_pixel(0, 255, 0);
		push_pixel(0, 0, 255);
		push_pixel(254, 0, 127);
		push_pixel(0, 254, 127);
		push_pixel(100, 0, 0);
		push_pixel(255, 255, 0);
		push_pixel(0, 0, 1);
		push_pixel(128, 128, 128);
		drain();

		run_random(FORMULA_DIFF, 0, 180);
		run_random(FORMULA_SUM, 55, 180);
		run_random(FORMULA_DIFF, 38, 180);
		run_random(FORMULA_SUM, 0, 180);
		run_random(FORMULA_SUM, 38, 190);
		run_random(FORMULA_DIFF, 55, 190);

		repeat (60) @(posedge clk);
		$display("Covered %0d pixels in %0d phases over both formula modes with sender idling.",
				n_pixels, n_phases);
		$display("Checked %0d words: %0d undefined, %0d on the code rails, %0d mismatches.",
				n_words, n_undefined, n_rail, n_errors);
		if (n_errors == 0 && phase_expect_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d words still expected", phase_expect_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
